// ----- rtl/ate_pkg.sv -----
// Shared constants, function codes and the store write bundle for the array table engine.
package ate_pkg;

  // Table geometry and field widths.
  localparam int ENTRIES = 64;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int CNT_W   = IDX_W + 1;
  localparam int DATA_W  = 32;

  // Operation codes carried by the func field.
  localparam logic [2:0] FN_GET       = 3'd0;
  localparam logic [2:0] FN_SET       = 3'd1;
  localparam logic [2:0] FN_INSERT    = 3'd2;
  localparam logic [2:0] FN_DELETE    = 3'd3;
  localparam logic [2:0] FN_SEARCH    = 3'd4;
  localparam logic [2:0] FN_SEARCH_TP = 3'd5;

  // Capacity after reset.
  localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(ENTRIES);

  // One write into the entry store.
  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  addr;
    logic [DATA_W-1:0] data;
  } ate_wr_t;

endpackage

// ----- rtl/ate_store.sv -----
// Entry store: one write port, one registered read port, per-entry valid bits for reset.
module ate_store (
  input  logic                        clk,
  input  logic                        rst,
  input  ate_pkg::ate_wr_t            wr,
  input  logic                        rd_en,
  input  logic [ate_pkg::IDX_W-1:0]   rd_addr,
  output logic [ate_pkg::DATA_W-1:0]  rd_data
);

  logic [ate_pkg::DATA_W-1:0]  mem [ate_pkg::ENTRIES];
  logic [ate_pkg::ENTRIES-1:0] valid;
  logic [ate_pkg::DATA_W-1:0]  mem_q;
  logic                        valid_q;

  // Storage array write.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // Valid bits: an entry never written since reset reads as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr.en) begin
      valid[wr.addr] <= 1'b1;
    end
  end

  // Registered read: the word shows on rd_data in the cycle after rd_en.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      mem_q   <= mem[rd_addr];
      valid_q <= valid[rd_addr];
    end
  end

  assign rd_data = valid_q ? mem_q : '0;

endmodule

// ----- rtl/array_table_engine_top.sv -----
// Array table engine top level: operation sequencer around the entry store.
//
// Usage: an item (func, position, operand_value) is taken on a rising edge with
// start high and busy low. Exactly one result per item appears on status,
// result_index, result_value and fill_length for one cycle with done high; the
// receiver cannot hold it off. capacity_limit is written through cfg_wr_en and
// cfg_wr_data; the user must write it only while no item is in flight, as the
// block itself does not enforce it.
// Rejected items, set, and inserts or deletes that move nothing finish straight
// from idle; get waits on the registered store read. An insert walks the moved
// entries and then writes the new value, a delete walks the moved entries, and a
// search the compared entries, one entry per cycle through the single read port
// of the store; a search with transpose adds a swap write on a hit away from the
// front. busy drops in the cycle done is shown, so the next item may be taken then.
// Reset (rst, synchronous) empties the table: all entries read zero, the fill
// length is zero and capacity_limit returns to 64. No clearing pass is needed.
module array_table_engine_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [2:0]                        func,
  input  logic [ate_pkg::IDX_W-1:0]         position,
  input  logic signed [ate_pkg::DATA_W-1:0] operand_value,
  input  logic                              cfg_wr_en,
  input  logic [ate_pkg::CNT_W-1:0]         cfg_wr_data,
  output logic                              done,
  output logic                              status,
  output logic [ate_pkg::IDX_W-1:0]         result_index,
  output logic signed [ate_pkg::DATA_W-1:0] result_value,
  output logic [ate_pkg::CNT_W-1:0]         fill_length
);

  typedef enum logic [6:0] {
    ST_IDLE      = 7'b0000001,
    ST_GET_WAIT  = 7'b0000010,
    ST_SHIFT_UP  = 7'b0000100,
    ST_INS_FINAL = 7'b0001000,
    ST_SHIFT_DN  = 7'b0010000,
    ST_SEARCH    = 7'b0100000,
    ST_SWAP      = 7'b1000000
  } state_t;

  state_t                      state, state_next;
  logic [ate_pkg::CNT_W-1:0]   capacity_limit;
  logic [ate_pkg::CNT_W-1:0]   fill, fill_next;
  logic [ate_pkg::IDX_W-1:0]   idx, idx_next;
  logic [ate_pkg::DATA_W-1:0]  prev, prev_next;
  logic [2:0]                  func_r;
  logic [ate_pkg::IDX_W-1:0]   pos_r;
  logic [ate_pkg::DATA_W-1:0]  val_r;

  logic [ate_pkg::CNT_W-1:0]   cap_eff;
  logic [ate_pkg::CNT_W-1:0]   ins_top;
  logic [ate_pkg::CNT_W-1:0]   fill_inc, fill_dec;
  logic                        pos_ok;
  logic                        accept;

  ate_pkg::ate_wr_t            wr;
  logic                        rd_en;
  logic [ate_pkg::IDX_W-1:0]   rd_addr;
  logic [ate_pkg::DATA_W-1:0]  rd_data;

  logic                        fin;
  logic                        fin_status;
  logic [ate_pkg::IDX_W-1:0]   fin_index;
  logic [ate_pkg::DATA_W-1:0]  fin_value;

  ate_store u_store (
    .clk     (clk),
    .rst     (rst),
    .wr      (wr),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Usable size, insert start point and fill length updates.
  assign cap_eff  = (capacity_limit < ate_pkg::CAP_RESET) ? capacity_limit : ate_pkg::CAP_RESET;
  assign pos_ok   = {1'b0, position} < cap_eff;
  assign ins_top  = (fill >= cap_eff) ? cap_eff - 1'b1 : fill;
  assign fill_inc = (fill < cap_eff) ? fill + 1'b1 : fill;
  assign fill_dec = (fill != '0) ? fill - 1'b1 : fill;
  assign busy     = (state != ST_IDLE);
  assign accept   = start && !busy;

  // Sequencer: at most one store read and at most one store write per cycle.
  always_comb begin
    state_next = state;
    idx_next   = idx;
    prev_next  = prev;
    fill_next  = fill;
    wr         = '0;
    rd_en      = 1'b0;
    rd_addr    = idx;
    fin        = 1'b0;
    fin_status = 1'b1;
    fin_index  = '0;
    fin_value  = '0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          if (func inside {ate_pkg::FN_SEARCH, ate_pkg::FN_SEARCH_TP}) begin
            if (fill == '0) begin
              fin = 1'b1;
            end else begin
              idx_next   = '0;
              rd_en      = 1'b1;
              rd_addr    = '0;
              prev_next  = '0;
              state_next = ST_SEARCH;
            end
          end else if (func > ate_pkg::FN_DELETE) begin
            fin = 1'b1;
          end else if (!pos_ok) begin
            fin       = 1'b1;
            fin_index = position;
          end else begin
            case (func)
              ate_pkg::FN_GET: begin
                rd_en      = 1'b1;
                rd_addr    = position;
                state_next = ST_GET_WAIT;
              end
              ate_pkg::FN_SET: begin
                wr.en      = 1'b1;
                wr.addr    = position;
                wr.data    = operand_value;
                fin        = 1'b1;
                fin_status = 1'b0;
                fin_index  = position;
              end
              ate_pkg::FN_INSERT: begin
                if (ins_top > {1'b0, position}) begin
                  idx_next   = ins_top[ate_pkg::IDX_W-1:0];
                  rd_en      = 1'b1;
                  rd_addr    = ins_top[ate_pkg::IDX_W-1:0] - 1'b1;
                  state_next = ST_SHIFT_UP;
                end else begin
                  wr.en      = 1'b1;
                  wr.addr    = position;
                  wr.data    = operand_value;
                  fill_next  = fill_inc;
                  fin        = 1'b1;
                  fin_status = 1'b0;
                  fin_index  = position;
                end
              end
              default: begin
                if (({1'b0, position} + 1'b1) < fill) begin
                  idx_next   = position;
                  rd_en      = 1'b1;
                  rd_addr    = position + 1'b1;
                  state_next = ST_SHIFT_DN;
                end else begin
                  fill_next  = fill_dec;
                  fin        = 1'b1;
                  fin_status = 1'b0;
                  fin_index  = position;
                end
              end
            endcase
          end
        end
      end
      ST_GET_WAIT: begin
        fin        = 1'b1;
        fin_status = 1'b0;
        fin_index  = pos_r;
        fin_value  = rd_data;
      end
      ST_SHIFT_UP: begin
        // Move entry idx-1 up into idx, walking down toward the insert point.
        wr.en   = 1'b1;
        wr.addr = idx;
        wr.data = rd_data;
        if ((idx - 1'b1) > pos_r) begin
          rd_en    = 1'b1;
          rd_addr  = idx - 2'd2;
          idx_next = idx - 1'b1;
        end else begin
          state_next = ST_INS_FINAL;
        end
      end
      ST_INS_FINAL: begin
        wr.en      = 1'b1;
        wr.addr    = pos_r;
        wr.data    = val_r;
        fill_next  = fill_inc;
        fin        = 1'b1;
        fin_status = 1'b0;
        fin_index  = pos_r;
      end
      ST_SHIFT_DN: begin
        // Move entry idx+1 down into idx, walking up to the end of the fill.
        wr.en   = 1'b1;
        wr.addr = idx;
        wr.data = rd_data;
        if (({1'b0, idx} + 2'd2) < fill) begin
          rd_en    = 1'b1;
          rd_addr  = idx + 2'd2;
          idx_next = idx + 1'b1;
        end else begin
          fill_next  = fill_dec;
          fin        = 1'b1;
          fin_status = 1'b0;
          fin_index  = pos_r;
        end
      end
      ST_SEARCH: begin
        if (rd_data == val_r) begin
          if ((func_r == ate_pkg::FN_SEARCH_TP) && (idx != '0)) begin
            // The match moves one place toward the front; the word before it takes its slot.
            wr.en      = 1'b1;
            wr.addr    = idx;
            wr.data    = prev;
            state_next = ST_SWAP;
          end else begin
            fin        = 1'b1;
            fin_status = 1'b0;
            fin_index  = idx;
          end
        end else begin
          prev_next = rd_data;
          if (({1'b0, idx} + 1'b1) < fill) begin
            rd_en    = 1'b1;
            rd_addr  = idx + 1'b1;
            idx_next = idx + 1'b1;
          end else begin
            fin = 1'b1;
          end
        end
      end
      ST_SWAP: begin
        wr.en      = 1'b1;
        wr.addr    = idx - 1'b1;
        wr.data    = val_r;
        fin        = 1'b1;
        fin_status = 1'b0;
        fin_index  = idx;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    if (fin) begin
      state_next = ST_IDLE;
    end
  end

  // Control state, fill length and capacity register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      fill           <= '0;
      capacity_limit <= ate_pkg::CAP_RESET;
      done           <= 1'b0;
    end else begin
      state <= state_next;
      fill  <= fill_next;
      done  <= fin;
      if (cfg_wr_en) begin
        capacity_limit <= cfg_wr_data;
      end
    end
  end

  // Working registers and the captured item.
  always_ff @(posedge clk) begin
    idx  <= idx_next;
    prev <= prev_next;
    if (accept) begin
      func_r <= func;
      pos_r  <= position;
      val_r  <= operand_value;
    end
  end

  // Result register, shown for one cycle with done.
  always_ff @(posedge clk) begin
    if (fin) begin
      status       <= fin_status;
      result_index <= fin_index;
      result_value <= $signed(fin_value);
      fill_length  <= fill_next;
    end
  end

  // The fill length never exceeds the table size.
  assert property (@(posedge clk) disable iff (rst) fill <= ate_pkg::CAP_RESET)
    else $error("fill length beyond table size");

  // A result is only shown once the sequencer is free again.
  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result shown while busy");

  // An accepted item is either still in work or finished in the next cycle.
  assert property (@(posedge clk) disable iff (rst) accept |=> (busy || done))
    else $error("accepted item lost");

  // The upward shift never walks below the insert point.
  assert property (@(posedge clk) disable iff (rst) (state == ST_SHIFT_UP) |-> (idx > pos_r))
    else $error("insert shift passed the insert point");

  // The transpose finishes the item in the cycle after the swap write.
  assert property (@(posedge clk) disable iff (rst) (state == ST_SWAP) |=> done)
    else $error("transpose did not finish");

endmodule
